>>> hdl/alr_pkg.sv
// Shared types, constants and helper functions for the associated Legendre row generator.
`timescale 1ns / 1ps

package alr_pkg;

    localparam int TERM_W     = 64;   // Q23.40 term width
    localparam int DEG_W      = 4;    // degree and order fields
    localparam int X_W        = 32;   // signed Q1.30 argument
    localparam int SINE_W     = 31;   // unsigned Q1.30 sine
    localparam int OPB_W      = 36;   // signed small-factor operand of the multiplier
    localparam int AMAG_W     = TERM_W - 1;
    localparam int DIG_W      = 18;   // multiplier digit consumed per cycle
    localparam int N_DIG      = OPB_W / DIG_W;
    localparam int ACC_W      = AMAG_W + OPB_W;
    localparam int FRAC_IN    = 30;
    localparam int DVS_W      = 4;    // divisor ll-m reaches eight when m is zero
    localparam int DIV_RADIX  = 8;    // quotient bits per divider cycle
    localparam int DIV_STEPS  = TERM_W / DIV_RADIX;

    localparam logic [DEG_W-1:0] MAX_DEGREE = 4'd8;

    localparam logic signed [TERM_W-1:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
    localparam logic signed [TERM_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [TERM_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0001;

    // Operand selection for the shared multiplier.
    localparam logic [1:0] MSEL_PMM = 2'd0;  // cur * -(2i-1)*s
    localparam logic [1:0] MSEL_XA  = 2'd1;  // cur * x*(2ll-1)
    localparam logic [1:0] MSEL_PB  = 2'd2;  // prev * (ll+m-1), no rescale

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [OPB_W-1:0]  opb_t;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       pmm_update;
        logic       adv_ll;
        logic       first_update;
        logic       a_capture;
        logic       diff_capture;
        logic       div_start;
        logic       rec_update;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic pmm_done;
        logic first_step;
        logic last;
        logic out_free;
        logic mul_done;
        logic div_done;
    } status_t;

    function automatic logic [DEG_W-1:0] clamp_deg(input logic [DEG_W-1:0] v);
        return (v > MAX_DEGREE) ? MAX_DEGREE : v;
    endfunction

    // Exact difference, saturated to the symmetric range.
    function automatic term_t sat_sub(input term_t a, input term_t b);
        logic [TERM_W:0] d;
        d = {a[TERM_W-1], a} - {b[TERM_W-1], b};
        if (!d[TERM_W] && d[TERM_W-1])
            return SAT_MAX;
        else if (d[TERM_W] && (!d[TERM_W-1] || d[TERM_W-2:0] == '0))
            return SAT_MIN;
        return term_t'(d[TERM_W-1:0]);
    endfunction

endpackage

>>> hdl/alr_mul.sv
// Iterative signed multiplier with floor rescale and symmetric saturation.
`timescale 1ns / 1ps

module alr_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  alr_pkg::term_t op_a,
    input  alr_pkg::opb_t  op_b,
    input  logic         frac_shift,
    output logic         done,
    output alr_pkg::term_t result
);
    import alr_pkg::*;

    localparam int PH_W = $clog2(N_DIG + 1);

    logic [AMAG_W-1:0]    a_mag_reg, a_mag_next;
    logic [OPB_W-1:0]     b_sh_reg, b_sh_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 shift_reg, shift_next;
    logic                 busy_reg, busy_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic                 done_reg, done_next;
    term_t                result_reg, result_next;

    logic [AMAG_W-1:0]       a_abs;
    logic [OPB_W-1:0]        b_abs;
    logic [AMAG_W+DIG_W-1:0] partial;
    logic [ACC_W-1:0]        acc_step;
    logic [ACC_W-1:0]        q_full;
    logic [TERM_W-2:0]       q_low;
    logic [TERM_W-1:0]       q_ext;
    logic                    rem;
    logic                    ovf;
    term_t                   fin;

    always_comb
    begin
        a_abs    = op_a[TERM_W-1] ? AMAG_W'(-op_a) : AMAG_W'(op_a);
        b_abs    = op_b[OPB_W-1] ? OPB_W'(-op_b) : OPB_W'(op_b);
        // Digits enter most significant first, so the accumulator shifts left each cycle.
        partial  = a_mag_reg * b_sh_reg[OPB_W-1 -: DIG_W];
        acc_step = (acc_reg << DIG_W) + ACC_W'(partial);

        q_full = shift_reg ? (acc_reg >> FRAC_IN) : acc_reg;
        rem    = shift_reg && (acc_reg[FRAC_IN-1:0] != '0);
        q_low  = q_full[TERM_W-2:0];
        q_ext  = {1'b0, q_low};
        // A negative product with a remainder rounds down one further step.
        ovf    = (q_full[ACC_W-1:TERM_W-1] != '0) || (neg_reg && rem && (&q_low));
        if (ovf)
            fin = neg_reg ? SAT_MIN : SAT_MAX;
        else if (neg_reg)
            fin = rem ? term_t'(~q_ext) : term_t'(-q_ext);
        else
            fin = term_t'(q_ext);
    end

    always_comb
    begin
        a_mag_next  = a_mag_reg;
        b_sh_next   = b_sh_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        shift_next  = shift_reg;
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (start)
        begin
            a_mag_next = a_abs;
            b_sh_next  = b_abs;
            acc_next   = '0;
            neg_next   = op_a[TERM_W-1] ^ op_b[OPB_W-1];
            shift_next = frac_shift;
            busy_next  = 1'b1;
            phase_next = '0;
        end
        else if (busy_reg)
        begin
            if (phase_reg != PH_W'(N_DIG))
            begin
                acc_next   = acc_step;
                b_sh_next  = b_sh_reg << DIG_W;
                phase_next = phase_reg + 1'b1;
            end
            else
            begin
                result_next = fin;
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        b_sh_reg   <= b_sh_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        shift_reg  <= shift_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hdl/alr_div.sv
// Iterative divider by a small unsigned divisor, truncating toward zero.
`timescale 1ns / 1ps

module alr_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  alr_pkg::term_t       dividend,
    input  logic [alr_pkg::DVS_W-1:0] divisor,
    output logic                 done,
    output alr_pkg::term_t       quotient
);
    import alr_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic [TERM_W-1:0] work_reg, work_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    term_t             quot_reg, quot_next;

    logic [TERM_W-1:0] w;
    logic [DVS_W-1:0]  r;
    logic [DVS_W:0]    t;

    // Restoring division, several quotient bits per cycle; the partial remainder
    // stays below the divisor, so every trial is a narrow compare.
    always_comb
    begin
        w = work_reg;
        r = rem_reg;
        for (int j = 0; j < DIV_RADIX; j++)
        begin
            t = {r, w[TERM_W-1]};
            w = {w[TERM_W-2:0], 1'b0};
            if (t >= {1'b0, dvs_reg})
            begin
                r    = DVS_W'(t - {1'b0, dvs_reg});
                w[0] = 1'b1;
            end
            else
            begin
                r = t[DVS_W-1:0];
            end
        end
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start)
        begin
            work_next = dividend[TERM_W-1] ? TERM_W'(-dividend) : TERM_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[TERM_W-1];
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != STEP_W'(DIV_STEPS))
            begin
                work_next = w;
                rem_next  = r;
                step_next = step_reg + 1'b1;
            end
            else
            begin
                quot_next = neg_reg ? term_t'(-work_reg) : term_t'(work_reg);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hdl/alr_datapath.sv
// Datapath: operand registers, term history, shared multiplier and divider, output register.
`timescale 1ns / 1ps

module alr_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  alr_pkg::cmd_t              cmd,
    output alr_pkg::status_t           status,
    input  logic [alr_pkg::DEG_W-1:0]  degree_l,
    input  logic [alr_pkg::DEG_W-1:0]  order_m,
    input  logic signed [alr_pkg::X_W-1:0] arg_x,
    input  logic [alr_pkg::SINE_W-1:0] arg_sine,
    input  logic                       out_ready,
    output logic                       out_valid,
    output alr_pkg::term_t             poly_value,
    output logic                       last_term
);
    import alr_pkg::*;

    logic [DEG_W-1:0]        l_reg, l_next;
    logic [DEG_W-1:0]        m_reg, m_next;
    logic signed [X_W-1:0]   x_reg, x_next;
    logic [SINE_W-1:0]       s_reg, s_next;
    logic [DEG_W-1:0]        i_reg, i_next;
    logic [DEG_W-1:0]        ll_reg, ll_next;
    term_t                   cur_reg, cur_next;
    term_t                   prev_reg, prev_next;
    term_t                   a_reg, a_next;
    term_t                   diff_reg, diff_next;
    logic                    out_valid_reg, out_valid_next;
    term_t                   out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    logic [DEG_W:0]          odd_i;
    logic [DEG_W:0]          odd_ll;
    logic [OPB_W-1:0]        pmm_mag;
    logic signed [X_W+DEG_W+1:0] xa_full;
    opb_t                    mul_b;
    term_t                   mul_a;
    logic                    mul_frac;
    logic                    mul_done;
    term_t                   mul_result;
    logic [DEG_W-1:0]        ll_minus_m;
    logic                    div_done;
    term_t                   div_result;

    // Small integer factors for the multiplier.
    always_comb
    begin
        odd_i   = {i_reg, 1'b0} - (DEG_W+1)'(1);
        odd_ll  = {ll_reg, 1'b0} - (DEG_W+1)'(1);
        pmm_mag = OPB_W'(s_reg) * OPB_W'(odd_i);
        xa_full = x_reg * $signed({1'b0, odd_ll});
        unique case (cmd.mul_sel)
            MSEL_PMM:
            begin
                mul_a    = cur_reg;
                mul_b    = opb_t'(-pmm_mag);
                mul_frac = 1'b1;
            end
            MSEL_XA:
            begin
                mul_a    = cur_reg;
                mul_b    = opb_t'(xa_full[OPB_W-1:0]);
                mul_frac = 1'b1;
            end
            default:
            begin
                mul_a    = prev_reg;
                mul_b    = opb_t'({1'b0, ll_reg} + {1'b0, m_reg} - (DEG_W+1)'(1));
                mul_frac = 1'b0;
            end
        endcase
        ll_minus_m = ll_reg - m_reg;
    end

    alr_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.mul_start),
        .op_a       (mul_a),
        .op_b       (mul_b),
        .frac_shift (mul_frac),
        .done       (mul_done),
        .result     (mul_result)
    );

    alr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff_reg),
        .divisor  (ll_minus_m[DVS_W-1:0]),
        .done     (div_done),
        .quotient (div_result)
    );

    always_comb
    begin
        l_next         = l_reg;
        m_next         = m_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        ll_next        = ll_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        a_next         = a_reg;
        diff_next      = diff_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cmd.load)
        begin
            l_next    = clamp_deg(degree_l);
            m_next    = clamp_deg(order_m);
            x_next    = arg_x;
            s_next    = arg_sine;
            i_next    = DEG_W'(1);
            ll_next   = clamp_deg(order_m);
            cur_next  = ONE_Q40;
            prev_next = '0;
        end
        if (cmd.pmm_update)
        begin
            cur_next = mul_result;
            i_next   = i_reg + 1'b1;
        end
        if (cmd.adv_ll)
            ll_next = ll_reg + 1'b1;
        if (cmd.first_update)
        begin
            prev_next = cur_reg;
            cur_next  = mul_result;
        end
        if (cmd.a_capture)
            a_next = mul_result;
        if (cmd.diff_capture)
            diff_next = sat_sub(a_reg, mul_result);
        if (cmd.rec_update)
        begin
            prev_next = cur_reg;
            cur_next  = div_result;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cur_reg;
            out_last_next  = (ll_reg >= l_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            ll_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            ll_reg        <= ll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg        <= l_next;
        m_reg        <= m_next;
        x_reg        <= x_next;
        s_reg        <= s_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        a_reg        <= a_next;
        diff_reg     <= diff_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        status.pmm_done   = (i_reg > m_reg);
        status.first_step = ({1'b0, ll_reg} == ({1'b0, m_reg} + (DEG_W+1)'(1)));
        status.last       = (ll_reg >= l_reg);
        status.out_free   = !out_valid_reg || out_ready;
        status.mul_done   = mul_done;
        status.div_done   = div_done;
    end

    assign out_valid  = out_valid_reg;
    assign poly_value = out_data_reg;
    assign last_term  = out_last_reg;

    // The degree counter never runs past the requested degree.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.adv_ll |=> (ll_reg <= l_reg))
        else $error("degree counter passed the row end");

    // The P_m^m factor counter stops one past the order.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pmm_update |=> ({1'b0, i_reg} <= ({1'b0, m_reg} + (DEG_W+1)'(1))))
        else $error("factor counter overran the order");

    // The divider only runs for the full recurrence, where ll-m is at least two.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> ({1'b0, ll_reg} >= ({1'b0, m_reg} + (DEG_W+1)'(2))))
        else $error("divider started with a divisor below two");

endmodule

>>> hdl/alr_ctrl.sv
// Controller state machine sequencing the factor loop, the recurrence and the result transfers.
`timescale 1ns / 1ps

module alr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  alr_pkg::status_t  status,
    output alr_pkg::cmd_t     cmd
);
    import alr_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PMM      = 4'd1;
    localparam logic [3:0] S_PMM_WAIT = 4'd2;
    localparam logic [3:0] S_EMIT     = 4'd3;
    localparam logic [3:0] S_MUL_A    = 4'd4;
    localparam logic [3:0] S_WAIT_A   = 4'd5;
    localparam logic [3:0] S_MUL_B    = 4'd6;
    localparam logic [3:0] S_WAIT_B   = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_WAIT_DIV = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PMM;
                end
            end
            S_PMM:
            begin
                if (status.pmm_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_PMM;
                    state_next    = S_PMM_WAIT;
                end
            end
            S_PMM_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.pmm_update = 1'b1;
                    state_next     = S_PMM;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.adv_ll = 1'b1;
                        state_next = S_MUL_A;
                    end
                end
            end
            S_MUL_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_XA;
                state_next    = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                if (status.mul_done)
                begin
                    // The term right after P_m^m has no older term and no divisor.
                    if (status.first_step)
                    begin
                        cmd.first_update = 1'b1;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        cmd.a_capture = 1'b1;
                        state_next    = S_MUL_B;
                    end
                end
            end
            S_MUL_B:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MSEL_PB;
                state_next    = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (status.mul_done)
                begin
                    cmd.diff_capture = 1'b1;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_DIV;
            end
            S_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.rec_update = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.last |=> (state_reg == S_IDLE))
        else $error("final term transferred but the sequencer did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (state_reg == S_PMM_WAIT || state_reg == S_WAIT_A
                             || state_reg == S_WAIT_B))
        else $error("multiplier result arrived while nobody waited for it");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_WAIT_DIV))
        else $error("divider result arrived while nobody waited for it");

endmodule

>>> hdl/associated_legendre_row.sv
// Top level of the associated Legendre row generator.
//
// One input transfer carries a degree l, an order m, x and sqrt(1-x^2). The block
// then sends P_m^m, P_{m+1}^m, ... P_l^m as separate output transfers, tlast set on
// the final one; with m not below l only P_m^m is sent. Degree and order above 8
// are treated as 8. Values are signed Q23.40, saturated to +-(2^63-1).
// Items are handled one at a time: s_axis_tready is high only while the sequencer
// is idle. P_m^m takes one pass of the shared multiplier per factor of P_m^m;
// P_{m+1}^m then takes one more pass, and each further term two passes of the
// multiplier (two 18-bit digits and a final step each) and the divider,
// which delivers 8 quotient bits per cycle. The output register lets the next input
// transfer be taken while the final result still waits; if the receiver holds
// m_axis_tready low, computation pauses at the next result until the register frees.
// Reset (rst_n low) returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps

module associated_legendre_row (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: degree_l[3:0], order_m[3:0], arg_x[31:0], arg_sine[30:0], zero pad.
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0 up: poly_value[63:0].
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import alr_pkg::*;

    cmd_t    cmd;
    status_t status;
    term_t   poly_value;

    alr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    alr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .degree_l   (s_axis_tdata[3:0]),
        .order_m    (s_axis_tdata[7:4]),
        .arg_x      (s_axis_tdata[39:8]),
        .arg_sine   (s_axis_tdata[70:40]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .poly_value (poly_value),
        .last_term  (m_axis_tlast)
    );

    assign m_axis_tdata = poly_value;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the associated Legendre row generator.
`timescale 1ns / 1ps

module tb;

    import alr_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_LEN       = 400;
    localparam int          TAIL_CYCLES    = 60;
    localparam logic [31:0] X_ONE          = 32'h4000_0000;
    localparam logic [31:0] X_HALF         = 32'h2000_0000;
    localparam logic [31:0] X_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] X_MIN          = 32'h8000_0000;
    localparam logic [30:0] S_ONE          = 31'h4000_0000;
    localparam logic [30:0] S_MAX          = 31'h7FFF_FFFF;
    localparam logic [30:0] S_HALF         = 31'd929887697;   // sqrt(0.75) in Q1.30

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    associated_legendre_row dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Expected terms in output order, with their end-of-row flags.
    term_t terms_due[$];
    logic  last_due[$];

    int   errors = 0;
    int   rows_sent = 0;
    int   terms_seen = 0;
    bit   gaps_on = 1'b0;
    bit   stall_on = 1'b0;
    bit   hold_go = 1'b0;
    bit   hold_seen = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    // Exact product, floor shift, saturated to +-(2^63-1).
    function automatic term_t mul_floor_sat(input term_t a, input term_t b, input int sh);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        logic signed [127:0] lim;
        wa = 128'(a);
        wb = 128'(b);
        lim = 128'(SAT_MAX);
        p = wa * wb;
        p = p >>> sh;
        if (p > lim)
            return SAT_MAX;
        if (p < -lim)
            return -SAT_MAX;
        return term_t'(p[63:0]);
    endfunction

    function automatic term_t diff_sat(input term_t a, input term_t b);
        logic signed [64:0] d;
        logic signed [64:0] lim;
        lim = 65'(SAT_MAX);
        d = 65'(a);
        d = d - 65'(b);
        if (d > lim)
            return SAT_MAX;
        if (d < -lim)
            return -SAT_MAX;
        return term_t'(d[63:0]);
    endfunction

    // Computes the row P_m^m .. P_l^m and queues every term in order.
    task automatic legendre_row_predict(input logic [3:0] l_in, input logic [3:0] m_in,
                                        input logic signed [31:0] x, input logic [30:0] s);
        int    l;
        int    m;
        int    ll;
        term_t prev;
        term_t cur;
        term_t fac;
        term_t a;
        term_t b;
        term_t dv;
        l = (l_in > MAX_DEGREE) ? int'(MAX_DEGREE) : int'(l_in);
        m = (m_in > MAX_DEGREE) ? int'(MAX_DEGREE) : int'(m_in);
        cur = ONE_Q40;
        for (int i = 1; i <= m; i++)
        begin
            fac = $signed({33'b0, s});
            fac = -fac * term_t'(2 * i - 1);
            cur = mul_floor_sat(cur, fac, 30);
        end
        terms_due.push_back(cur);
        last_due.push_back(l <= m);
        prev = '0;
        ll = m;
        if (l > m)
        begin
            prev = cur;
            fac = term_t'(x);
            fac = fac * term_t'(2 * m + 1);
            cur = mul_floor_sat(fac, prev, 30);
            terms_due.push_back(cur);
            last_due.push_back(l == m + 1);
            for (ll = m + 2; ll <= l; ll++)
            begin
                fac = term_t'(x);
                fac = fac * term_t'(2 * ll - 1);
                a = mul_floor_sat(fac, cur, 30);
                b = mul_floor_sat(prev, term_t'(ll + m - 1), 0);
                dv = term_t'(ll - m);
                prev = cur;
                cur = diff_sat(a, b) / dv;
                terms_due.push_back(cur);
                last_due.push_back(ll == l);
            end
        end
    endtask

    // Offers one row request and returns at the edge of its transfer.
    task automatic send_row(input logic [3:0] l, input logic [3:0] m,
                            input logic [31:0] x, input logic [30:0] s);
        while (gaps_on && $urandom_range(0, 99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, s, x, m, l};
        do
            @(posedge clk);
        while (!s_axis_tready);
        legendre_row_predict(l, m, x, s);
        rows_sent++;
    endtask

    // Mostly consistent x and sine with legal l and m; the rest is raw noise.
    task automatic send_random_row();
        logic [3:0]         l;
        logic [3:0]         m;
        logic signed [31:0] x;
        logic [30:0]        s;
        real                xr;
        if ($urandom_range(0, 99) < 80)
        begin
            l = 4'($urandom_range(0, 8));
            m = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(0, l));
            case ($urandom_range(0, 9))
                0:       x = X_ONE;
                1:       x = -X_ONE;
                default: x = $signed($urandom_range(0, 32'h8000_0000)) - $signed(X_ONE);
            endcase
            xr = $itor(x) / 1073741824.0;
            s = 31'($rtoi($sqrt(1.0 - xr * xr) * 1073741824.0));
        end
        else
        begin
            l = 4'($urandom);
            m = 4'($urandom);
            x = $urandom;
            s = 31'($urandom);
        end
        send_row(l, m, x, s);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (terms_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        gaps_on  <= 1'b1;
        stall_on <= 1'b1;
        send_row(4'd0, 4'd0, 32'd0, 31'd0);        // P_0^0 alone
        send_row(4'd8, 4'd0, X_HALF, S_HALF);
        send_row(4'd8, 4'd0, X_ONE, 31'd0);
        send_row(4'd8, 4'd0, -X_ONE, 31'd0);
        send_row(4'd8, 4'd1, X_HALF, S_HALF);
        send_row(4'd8, 4'd4, -X_HALF, S_HALF);
        send_row(4'd8, 4'd7, X_HALF, S_HALF);
        send_row(4'd8, 4'd8, X_HALF, S_HALF);      // order equal to degree
        send_row(4'd3, 4'd5, X_HALF, S_HALF);      // order above degree
        send_row(4'd15, 4'd15, X_HALF, S_HALF);    // both clamped
        send_row(4'd15, 4'd2, -X_HALF, S_HALF);
        send_row(4'd4, 4'd12, X_HALF, S_HALF);
        send_row(4'd8, 4'd8, 32'd0, S_ONE);
        send_row(4'd8, 4'd8, 32'd0, S_MAX);        // sine out of range, saturates
        send_row(4'd8, 4'd0, X_MAX, 31'd0);
        send_row(4'd8, 4'd0, X_MIN, 31'd0);
        send_row(4'd8, 4'd3, X_MAX, S_MAX);
        send_row(4'd1, 4'd0, X_ONE, 31'd0);
        send_row(4'd2, 4'd0, 32'd0, S_ONE);
        send_row(4'd5, 4'd2, -X_ONE, 31'd0);
        send_row(4'd6, 4'd1, 32'h1000_0000, 31'd1039850106);
        send_row(4'd0, 4'd8, X_MIN, S_MAX);
        wait_drain();
    endtask

    // Back-to-back rows with both sides always ready.
    task automatic test_burst();
        gaps_on  <= 1'b0;
        stall_on <= 1'b0;
        repeat (40) send_random_row();
        wait_drain();
    endtask

    task automatic test_random();
        gaps_on  <= 1'b1;
        stall_on <= 1'b1;
        repeat (96) send_random_row();
        wait_drain();
    endtask

    // The receiver stops for a long stretch while rows keep coming.
    task automatic test_backpressure();
        gaps_on <= 1'b0;
        hold_go <= ~hold_go;
        repeat (12) send_random_row();
        wait_drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen     <= hold_go;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_on)
            m_axis_tready <= ($urandom_range(0, 99) >= 26);
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            terms_seen++;
            if (terms_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected term: expected none, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                if (m_axis_tdata !== terms_due[0])
                begin
                    errors++;
                    $display("%0t: poly_value mismatch: expected %h, actual %h",
                             $time, terms_due[0], m_axis_tdata);
                end
                if (m_axis_tlast !== last_due[0])
                begin
                    errors++;
                    $display("%0t: last_term mismatch: expected %b, actual %b",
                             $time, last_due[0], m_axis_tlast);
                end
                void'(terms_due.pop_front());
                void'(last_due.pop_front());
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d terms outstanding",
                     $time, WATCHDOG_LIMIT, terms_due.size());
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_burst();
        test_random();
        test_backpressure();
        $display("Covered %0d rows and %0d terms: field extremes, clamping, saturation,",
                 rows_sent, terms_seen);
        $display("random rows with idling on both sides, a gapless burst and a long output stall.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
